@@ design/message_bundle_deframer_macros.svh @@
// Assertion macros shared by the checker of the message bundle deframer.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef MESSAGE_BUNDLE_DEFRAMER_MACROS_SVH
`define MESSAGE_BUNDLE_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MBD_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed: label");

// Next-cycle implication, sampled on clk, off during reset.
`define MBD_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed: label");

`endif

@@ design/mbd_pkg.sv @@
// Package for the message bundle deframer: payload structs, codes, sizing.
// Depends on nothing; used by every module of the block.
package mbd_pkg;

	localparam int BUFFER_BYTES = 4096;
	localparam int TAKEN_W = $clog2(BUFFER_BYTES + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_DESC    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_LEN  = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_TRAILING  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  msg_index;
		logic [15:0] sequence_res;
		logic [15:0] payload_length;
		logic [7:0]  msg_type;
		logic [7:0]  payload_byte;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

@@ design/message_bundle_deframer.sv @@
// Top level of the message bundle deframer: input register, deframing core, result queue.
// Depends on mbd_pkg, mbd_core and mbd_outq.
//
// Usage:
// - item channel: one datagram byte per transfer, last_byte set on its final byte.
//   The first byte of a datagram is the message count.
// - res channel: per message one descriptor (kind 0), then each payload byte
//   (kind 1); after the flagged byte a verdict (kind 2, last = 1).
// - Path: a result passes through the input register, then the result queue,
//   before it appears on res. A verdict caused with another result is queued
//   right behind it.
// - Throughput: one byte per cycle while res_ready stays high. Every byte yields
//   at most one result except the flagged byte, which can yield two; the
//   four-entry queue absorbs that extra result.
// - Stall: while res_ready is low the queue fills; the input register holds
//   its byte once fewer than two queue entries are free, and item_ready drops.
// - Reset: arst_n clears the queue and returns the parser to waiting for a
//   count byte; any partly received datagram is forgotten.
module message_bundle_deframer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  mbd_pkg::item_t   item,
	output logic             res_valid,
	input  logic             res_ready,
	output mbd_pkg::result_t res
);
	import mbd_pkg::*;

	item_t              item_s1;
	logic               valid_s1;
	logic               advance;
	logic               room;
	logic [QCNT_W-1:0]  q_count;
	result_t            core_res0, core_res1;
	logic [1:0]         core_count;
	logic [1:0]         push_count;

	// Advance the held byte only when the queue can take two results,
	// counting the entry that leaves this cycle.
	assign room       = (q_count <= QCNT_W'(QUEUE_DEPTH - 2)) ||
	                    ((q_count == QCNT_W'(QUEUE_DEPTH - 1)) && res_ready);
	assign advance    = valid_s1 && room;
	assign item_ready = !valid_s1 || advance;
	assign push_count = advance ? core_count : 2'd0;

	// Input register: load on every input transfer, drop valid once consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	mbd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.res0      (core_res0),
		.res1      (core_res1),
		.res_count (core_count)
	);

	mbd_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (core_res0),
		.push1      (core_res1),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res        (res),
		.count      (q_count)
	);

endmodule

@@ design/mbd_core.sv @@
// Deframing state machine: consumes one byte per advance, forms up to two results.
// Depends on mbd_pkg.
module mbd_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  mbd_pkg::item_t  item_s1,
	output mbd_pkg::result_t res0,
	output mbd_pkg::result_t res1,
	output logic [1:0]      res_count
);
	import mbd_pkg::*;

	typedef enum logic [2:0] {
		PH_COUNT   = 3'd0,
		PH_SEQ_LO  = 3'd1,
		PH_SEQ_HI  = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_LEN_HI  = 3'd4,
		PH_TYPE    = 3'd5,
		PH_PAYLOAD = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [7:0]           msgs_left_q, msgs_left_d;
	logic [7:0]           idx_q, idx_d;
	logic [15:0]          seq_q, seq_d;
	logic [15:0]          len_q, len_d;
	logic [15:0]          pl_left_q, pl_left_d;
	logic [TAKEN_W-1:0]   taken_q, taken_d;
	status_t              err_q, err_d;

	logic [15:0]          pl_new;
	logic [7:0]           msgs_dec;
	status_t              verdict;
	result_t              vres;

	always_comb begin
		phase_d     = phase_q;
		msgs_left_d = msgs_left_q;
		idx_d       = idx_q;
		seq_d       = seq_q;
		len_d       = len_q;
		pl_left_d   = pl_left_q;
		taken_d     = taken_q;
		err_d       = err_q;
		res0        = '0;
		res1        = '0;
		res_count   = 2'd0;
		pl_new      = 16'd0;
		msgs_dec    = msgs_left_q - 8'd1;
		verdict     = ST_OK;
		vres        = '0;

		if (phase_q == PH_COUNT) begin
			msgs_left_d = item_s1.data_byte;
			idx_d       = 8'd0;
			seq_d       = 16'd0;
			len_d       = 16'd0;
			pl_left_d   = 16'd0;
			taken_d     = '0;
			err_d       = ST_OK;
			phase_d     = (item_s1.data_byte == 8'd0) ? PH_DONE : PH_SEQ_LO;
		end else if (err_q == ST_OK && taken_q < TAKEN_W'(BUFFER_BYTES)) begin
			taken_d = taken_q + TAKEN_W'(1);
			unique case (phase_q)
				PH_SEQ_LO: begin
					seq_d   = {8'd0, item_s1.data_byte};
					phase_d = PH_SEQ_HI;
				end
				PH_SEQ_HI: begin
					seq_d   = {item_s1.data_byte, seq_q[7:0]};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d   = {8'd0, item_s1.data_byte};
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d   = {item_s1.data_byte, len_q[7:0]};
					phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					if (len_q == 16'd0) begin
						err_d = ST_ZERO_LEN;
					end else begin
						pl_new              = len_q - 16'd1;
						pl_left_d           = pl_new;
						res0.kind           = KIND_DESC;
						res0.msg_index      = idx_q;
						res0.sequence_res   = seq_q;
						res0.payload_length = pl_new;
						res0.msg_type       = item_s1.data_byte;
						res_count           = 2'd1;
						if (pl_new == 16'd0) begin
							idx_d       = idx_q + 8'd1;
							msgs_left_d = msgs_dec;
							phase_d     = (msgs_dec == 8'd0) ? PH_DONE : PH_SEQ_LO;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					res0.kind         = KIND_PAYLOAD;
					res0.msg_index    = idx_q;
					res0.payload_byte = item_s1.data_byte;
					res_count         = 2'd1;
					pl_left_d         = pl_left_q - 16'd1;
					if (pl_left_d == 16'd0) begin
						idx_d       = idx_q + 8'd1;
						msgs_left_d = msgs_dec;
						phase_d     = (msgs_dec == 8'd0) ? PH_DONE : PH_SEQ_LO;
					end
				end
				default: begin
					err_d = ST_TRAILING;
				end
			endcase
		end

		if (item_s1.last_byte) begin
			if (err_d != ST_OK)
				verdict = err_d;
			else if (phase_d == PH_DONE)
				verdict = ST_OK;
			else
				verdict = ST_TRUNCATED;
			vres.kind   = KIND_VERDICT;
			vres.status = verdict;
			vres.last   = 1'b1;
			if (res_count == 2'd1)
				res1 = vres;
			else
				res0 = vres;
			res_count = res_count + 2'd1;
			phase_d   = PH_COUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_COUNT;
			msgs_left_q <= '0;
			idx_q       <= '0;
			seq_q       <= '0;
			len_q       <= '0;
			pl_left_q   <= '0;
			taken_q     <= '0;
			err_q       <= ST_OK;
		end else if (advance) begin
			phase_q     <= phase_d;
			msgs_left_q <= msgs_left_d;
			idx_q       <= idx_d;
			seq_q       <= seq_d;
			len_q       <= len_d;
			pl_left_q   <= pl_left_d;
			taken_q     <= taken_d;
			err_q       <= err_d;
		end
	end

endmodule

@@ design/mbd_outq.sv @@
// Result queue: takes zero to two results per cycle, hands out one per transfer.
// Depends on mbd_pkg.
module mbd_outq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [1:0]              push_count,
	input  mbd_pkg::result_t        push0,
	input  mbd_pkg::result_t        push1,
	input  logic                    res_ready,
	output logic                    res_valid,
	output mbd_pkg::result_t        res,
	output logic [mbd_pkg::QCNT_W-1:0] count
);
	import mbd_pkg::*;

	result_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               pop;
	logic [QPTR_W-1:0]  wr_next;

	assign res_valid = (count_q != '0);
	assign res       = entry_q[rd_ptr_q];
	assign count     = count_q;
	assign pop       = res_valid && res_ready;
	assign wr_next   = wr_ptr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_count != 2'd0)
			entry_q[wr_ptr_q] <= push0;
		if (push_count == 2'd2)
			entry_q[wr_next] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push_count) - QCNT_W'(pop);
		end
	end

endmodule

@@ design/mbd_checker.sv @@
// Port-level checks for the message bundle deframer, bound to the top level.
// Depends on mbd_pkg and message_bundle_deframer_macros.svh.
`include "message_bundle_deframer_macros.svh"

module mbd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_ready,
	input logic             res_valid,
	input logic             res_ready,
	input mbd_pkg::result_t res
);
	import mbd_pkg::*;

	`MBD_ASSERT_NEXT(a_res_hold_valid, res_valid && !res_ready, res_valid)
	`MBD_ASSERT_NEXT(a_res_hold_data, res_valid && !res_ready, $stable(res))
	`MBD_ASSERT_NOW(a_verdict_clean, res_valid && res.kind == KIND_VERDICT,
		res.last && res.msg_index == 8'd0 && res.sequence_res == 16'd0 &&
		res.payload_length == 16'd0 && res.msg_type == 8'd0 && res.payload_byte == 8'd0)
	`MBD_ASSERT_NOW(a_data_not_last, res_valid && res.kind != KIND_VERDICT,
		!res.last && res.status == ST_OK)
	`MBD_ASSERT_NOW(a_ready_when_empty, !res_valid, item_ready)

endmodule

bind message_bundle_deframer mbd_checker u_mbd_checker (.*);
